// ----- src/ctpf_pkg.sv -----
// ----------------------------------------------------------------------------
// ctpf_pkg: shared types, constants and CRC helpers for the pack framer
// Pack layout, payload buffer type and the byte-wise CRC-16 step.
// ----------------------------------------------------------------------------
`default_nettype none

package ctpf_pkg;

  localparam int unsigned PayloadBytes = 12;
  localparam int unsigned HeaderBytes  = 4;
  localparam int unsigned PackBytes    = HeaderBytes + PayloadBytes;
  localparam int unsigned MaxBlocks    = 8;
  localparam int unsigned CrcStages    = 4;
  localparam int unsigned StageBytes   = PackBytes / CrcStages;

  localparam logic [7:0]  SizeinfoType = 8'h8F;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [3:0]  PosMax       = 4'd15;

  // byte 0 sits in the most significant position
  typedef logic [0:PayloadBytes-1][7:0] payload_t;

  typedef struct packed {
    logic [7:0] ptype;
    logic [7:0] track;
    logic [7:0] seq;
    logic [6:0] bpos;
    payload_t   payload;
  } pack_t;

  // MSB-first CRC-16 update by one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // byte idx of the 16-byte header+payload sequence
  function automatic logic [7:0] pack_byte(input pack_t p, input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = p.ptype;
      4'd1:    b = p.track;
      4'd2:    b = p.seq;
      4'd3:    b = {1'b0, p.bpos};
      default: b = p.payload[4'(idx - 4'(HeaderBytes))];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- src/ctpf_if.sv -----
// ----------------------------------------------------------------------------
// ctpf_in_if / ctpf_out_if: valid/ready channels of the pack framer
// Text byte request channel and framed pack result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctpf_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] text_byte;
  logic [7:0] txt_type;
  logic [6:0] txt_track;
  logic [2:0] txt_block;
  logic       string_start;

  modport source (
    output valid, opcode, text_byte, txt_type, txt_track, txt_block, string_start,
    input  ready
  );
  modport sink (
    input  valid, opcode, text_byte, txt_type, txt_track, txt_block, string_start,
    output ready
  );
endinterface

interface ctpf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_type;
  logic [7:0]  out_track;
  logic [7:0]  out_sequence;
  logic [6:0]  out_block_position;
  logic [47:0] payload_front;
  logic [47:0] payload_back;
  logic [15:0] pack_crc;

  modport source (
    output valid, out_type, out_track, out_sequence, out_block_position,
           payload_front, payload_back, pack_crc,
    input  ready
  );
  modport sink (
    input  valid, out_type, out_track, out_sequence, out_block_position,
           payload_front, payload_back, pack_crc,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/cd_text_pack_framer.sv -----
// ----------------------------------------------------------------------------
// cd_text_pack_framer: CD-TEXT pack framer
// Usage:
//   txt_i carries one request per text byte (opcode 0) or a flush (opcode 1)
//   with its pack type, track, block and string-start mark. pack_o carries
//   one 18-byte pack per result: four header bytes, twelve payload bytes
//   and the inverted CRC-16.
//   A request is taken in every cycle while the output is free or being
//   taken; one request per clock is the sustained rate.
//   A pack is registered at the edge that accepts the request completing
//   it (full, type or block change, flush) and then passes four CRC stages
//   of four bytes each before it shows on pack_o.
//   Up to five packs may be in flight.
//   When pack_o stalls, the pipeline and txt_i.ready hold together; no
//   request is taken and nothing is lost.
//   Reset clears the open pack, fill count, string position and the
//   per-block sequence and size-info counters; the pipeline is emptied.
//   Bytes with a block number at or beyond BLOCK_COUNT are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_text_pack_framer import ctpf_pkg::*; #(
  parameter int unsigned BLOCK_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctpf_in_if.sink     txt_i,
  ctpf_out_if.source  pack_o
);

  localparam int unsigned BlkIdxW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int unsigned LastStg = CrcStages;

  // framer state
  logic             open_q, open_d;
  logic [3:0]       fill_q, fill_d;
  logic [3:0]       spos_q, spos_d;
  logic [7:0]       hdr_type_q, hdr_type_d;
  logic [7:0]       hdr_track_q, hdr_track_d;
  logic [7:0]       hdr_seq_q, hdr_seq_d;
  logic [6:0]       hdr_bpos_q, hdr_bpos_d;
  payload_t         pay_q, pay_d;
  logic [7:0]       blk_seq_q [BLOCK_COUNT];
  logic [7:0]       blk_seq_d [BLOCK_COUNT];
  logic [7:0]       blk_si_q  [BLOCK_COUNT];
  logic [7:0]       blk_si_d  [BLOCK_COUNT];

  // CRC pipeline
  logic             stg_vld_q  [CrcStages+1];
  logic             stg_vld_d  [CrcStages+1];
  pack_t            stg_pack_q [CrcStages+1];
  pack_t            stg_pack_d [CrcStages+1];
  logic [15:0]      stg_crc_q  [CrcStages+1];
  logic [15:0]      stg_crc_d  [CrcStages+1];

  logic             advance;
  logic             accept;
  logic             emit;
  pack_t            emit_pack;
  logic             blk_ok;
  logic [BlkIdxW-1:0] blk_idx;

  assign advance     = !stg_vld_q[LastStg] || pack_o.ready;
  assign txt_i.ready = advance;
  assign accept      = txt_i.valid && advance;
  assign blk_ok      = {1'b0, txt_i.txt_block} < 4'(BLOCK_COUNT);
  assign blk_idx     = txt_i.txt_block[BlkIdxW-1:0];

  always_comb begin
    logic       change;
    logic [3:0] sp;
    logic [3:0] fill_v;
    payload_t   pay_v;

    open_d      = open_q;
    fill_d      = fill_q;
    spos_d      = spos_q;
    hdr_type_d  = hdr_type_q;
    hdr_track_d = hdr_track_q;
    hdr_seq_d   = hdr_seq_q;
    hdr_bpos_d  = hdr_bpos_q;
    pay_d       = pay_q;
    blk_seq_d   = blk_seq_q;
    blk_si_d    = blk_si_q;
    emit        = 1'b0;
    emit_pack   = '{ptype: hdr_type_q, track: hdr_track_q, seq: hdr_seq_q,
                    bpos: hdr_bpos_q, payload: pay_q};
    change      = 1'b0;
    sp          = spos_q;
    fill_v      = fill_q;
    pay_v       = pay_q;

    if (accept) begin
      if (txt_i.opcode) begin
        if (open_q) begin
          emit   = 1'b1;
          open_d = 1'b0;
          fill_d = '0;
        end
      end else if (blk_ok) begin
        sp     = txt_i.string_start ? 4'd0 : spos_q;
        change = open_q && (txt_i.txt_type != hdr_type_q ||
                            hdr_bpos_q[6:4] != txt_i.txt_block);
        // old pack leaves before the new byte opens its own
        if (change) begin
          emit = 1'b1;
        end
        if (!open_q || change) begin
          pay_v              = '0;
          fill_v             = '0;
          hdr_type_d         = txt_i.txt_type;
          hdr_seq_d          = blk_seq_q[blk_idx];
          blk_seq_d[blk_idx] = blk_seq_q[blk_idx] + 8'd1;
          if (txt_i.txt_type == SizeinfoType) begin
            hdr_track_d       = blk_si_q[blk_idx];
            blk_si_d[blk_idx] = blk_si_q[blk_idx] + 8'd1;
            hdr_bpos_d        = {txt_i.txt_block, 4'd0};
          end else begin
            hdr_track_d = {1'b0, txt_i.txt_track};
            hdr_bpos_d  = {txt_i.txt_block, sp};
          end
          open_d = 1'b1;
        end
        pay_v[fill_v] = txt_i.text_byte;
        fill_v        = fill_v + 4'd1;
        spos_d        = (sp == PosMax) ? sp : sp + 4'd1;
        if (fill_v == 4'(PayloadBytes) && !change) begin
          emit      = 1'b1;
          emit_pack = '{ptype: hdr_type_q, track: hdr_track_q, seq: hdr_seq_q,
                        bpos: hdr_bpos_q, payload: pay_v};
          open_d    = 1'b0;
          fill_v    = '0;
        end
        pay_d  = pay_v;
        fill_d = fill_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      fill_q      <= '0;
      spos_q      <= '0;
      hdr_type_q  <= '0;
      hdr_track_q <= '0;
      hdr_seq_q   <= '0;
      hdr_bpos_q  <= '0;
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        blk_seq_q[i] <= '0;
        blk_si_q[i]  <= '0;
      end
    end else begin
      open_q      <= open_d;
      fill_q      <= fill_d;
      spos_q      <= spos_d;
      hdr_type_q  <= hdr_type_d;
      hdr_track_q <= hdr_track_d;
      hdr_seq_q   <= hdr_seq_d;
      hdr_bpos_q  <= hdr_bpos_d;
      blk_seq_q   <= blk_seq_d;
      blk_si_q    <= blk_si_d;
    end
  end

  // payload bytes are cleared when a pack opens
  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  // each stage folds four bytes into the running CRC
  always_comb begin
    logic [15:0] c;
    stg_vld_d[0]  = emit;
    stg_pack_d[0] = emit_pack;
    stg_crc_d[0]  = '0;
    for (int k = 0; k < CrcStages; k++) begin
      c = stg_crc_q[k];
      for (int j = 0; j < StageBytes; j++) begin
        c = crc_byte(c, pack_byte(stg_pack_q[k], 4'(k * StageBytes + j)));
      end
      stg_vld_d[k+1]  = stg_vld_q[k];
      stg_pack_d[k+1] = stg_pack_q[k];
      stg_crc_d[k+1]  = c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= CrcStages; k++) begin
        stg_vld_q[k] <= 1'b0;
      end
    end else if (advance) begin
      stg_vld_q <= stg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stg_pack_q <= stg_pack_d;
      stg_crc_q  <= stg_crc_d;
    end
  end

  assign pack_o.valid              = stg_vld_q[LastStg];
  assign pack_o.out_type           = stg_pack_q[LastStg].ptype;
  assign pack_o.out_track          = stg_pack_q[LastStg].track;
  assign pack_o.out_sequence       = stg_pack_q[LastStg].seq;
  assign pack_o.out_block_position = stg_pack_q[LastStg].bpos;
  assign pack_o.payload_front      = stg_pack_q[LastStg].payload[0:5];
  assign pack_o.payload_back       = stg_pack_q[LastStg].payload[6:11];
  assign pack_o.pack_crc           = ~stg_crc_q[LastStg];

endmodule

`default_nettype wire

// ----- src/ctpf_checker.sv -----
// ----------------------------------------------------------------------------
// ctpf_checker: port-level checks for the pack framer
// Output hold under stall, request/result coupling, size-info header form.
// ----------------------------------------------------------------------------
`default_nettype none

module ctpf_checker import ctpf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_type,
  input logic [6:0]  out_block_position,
  input logic [47:0] payload_front,
  input logic [15:0] pack_crc
);

  // a stalled pack holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(payload_front) && $stable(pack_crc))
    else $error("stalled pack changed");

  // requests are taken exactly when the output slot frees up
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready == (!out_valid || out_ready))
    else $error("request ready not tied to output slot");

  // size-info packs carry a zero position nibble
  a_sizeinfo_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_type == SizeinfoType |-> out_block_position[3:0] == 4'd0)
    else $error("size-info pack with nonzero position");

endmodule

bind cd_text_pack_framer ctpf_checker u_ctpf_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready           (txt_i.ready),
  .out_valid          (pack_o.valid),
  .out_ready          (pack_o.ready),
  .out_type           (pack_o.out_type),
  .out_block_position (pack_o.out_block_position),
  .payload_front      (pack_o.payload_front),
  .pack_crc           (pack_o.pack_crc)
);

`default_nettype wire

// ----- dv/ctpf_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// ctpf_tb_pkg: verification constants for the pack framer
// Request opcodes and pack type codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ctpf_tb_pkg;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } ctpf_op_e;

  localparam logic [7:0] FirstTextType = 8'h80;
  localparam logic [7:0] LastTextType  = 8'h8E;

endpackage

`default_nettype wire

// ----- dv/ctpf_checker.sv -----
// ----------------------------------------------------------------------------
// ctpf_scoreboard: pack framer scoreboard
// Watches both channels, frames accepted text bytes into packs on its own
// and compares every pack taken from the block with the oldest one framed.
// ----------------------------------------------------------------------------
`default_nettype none

module ctpf_scoreboard import ctpf_pkg::*; import ctpf_tb_pkg::*; #(
  parameter int unsigned BLOCK_COUNT = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  ctpf_in_if   txt_i,
  ctpf_out_if  pack_i,
  output int   mismatches_o,
  output int   pending_o
);

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [7:0]  ptype;
    logic [7:0]  track;
    logic [7:0]  seq;
    logic [6:0]  bpos;
    logic [47:0] front;
    logic [47:0] back;
    logic [15:0] crc;
  } pack_rec_t;

  pack_rec_t   expected_packs[$];
  int          mismatch_cnt = 0;

  // framing state
  logic [7:0]  text_buf [PayloadBytes];
  int unsigned fill_cnt;
  bit          open_q;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_track;
  logic [7:0]  hdr_seq;
  logic [6:0]  hdr_bpos;
  logic [7:0]  seq_cnt [MaxBlocks];
  logic [7:0]  sizeinfo_cnt [MaxBlocks];
  logic [3:0]  str_pos;

  // bit-serial form of the MSB-first CRC-16
  function automatic logic [15:0] crc16_bits(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

  task automatic close_pack();
    pack_rec_t   rec;
    logic [15:0] crc;
    rec = '0;
    crc = 16'h0000;
    crc = crc16_bits(crc, hdr_type);
    crc = crc16_bits(crc, hdr_track);
    crc = crc16_bits(crc, hdr_seq);
    crc = crc16_bits(crc, {1'b0, hdr_bpos});
    for (int i = 0; i < PayloadBytes; i++) begin
      crc = crc16_bits(crc, text_buf[i]);
    end
    for (int i = 0; i < PayloadBytes / 2; i++) begin
      rec.front = {rec.front[39:0], text_buf[i]};
      rec.back  = {rec.back[39:0], text_buf[i + PayloadBytes / 2]};
    end
    rec.ptype = hdr_type;
    rec.track = hdr_track;
    rec.seq   = hdr_seq;
    rec.bpos  = hdr_bpos;
    rec.crc   = ~crc;
    expected_packs.push_back(rec);
    open_q   = 1'b0;
    fill_cnt = 0;
  endtask

  task automatic frame_request(input logic op, input logic [7:0] b, input logic [7:0] t,
                               input logic [6:0] trk, input logic [2:0] blk,
                               input logic st);
    bit closed;
    closed = 1'b0;
    if (op == OP_FLUSH) begin
      if (open_q) begin
        close_pack();
      end
      return;
    end
    if (blk >= BLOCK_COUNT) begin
      return;
    end
    if (st) begin
      str_pos = '0;
    end
    // a type or block change closes the current pack first
    if (open_q && (t != hdr_type || hdr_bpos[6:4] != blk)) begin
      close_pack();
      closed = 1'b1;
    end
    if (!open_q) begin
      for (int i = 0; i < PayloadBytes; i++) begin
        text_buf[i] = '0;
      end
      fill_cnt     = 0;
      hdr_type     = t;
      hdr_seq      = seq_cnt[blk];
      seq_cnt[blk] = seq_cnt[blk] + 8'd1;
      if (t == SizeinfoType) begin
        hdr_track         = sizeinfo_cnt[blk];
        sizeinfo_cnt[blk] = sizeinfo_cnt[blk] + 8'd1;
        hdr_bpos          = {blk, 4'd0};
      end else begin
        hdr_track = {1'b0, trk};
        hdr_bpos  = {blk, str_pos};
      end
      open_q = 1'b1;
    end
    if (fill_cnt < PayloadBytes) begin
      text_buf[fill_cnt] = b;
    end
    fill_cnt++;
    if (str_pos != PosMax) begin
      str_pos = str_pos + 4'd1;
    end
    if (fill_cnt >= PayloadBytes && !closed) begin
      close_pack();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pack_rec_t seen;
    pack_rec_t want;
    if (!rst_ni) begin
      for (int i = 0; i < PayloadBytes; i++) begin
        text_buf[i] = '0;
      end
      for (int i = 0; i < MaxBlocks; i++) begin
        seq_cnt[i]      = '0;
        sizeinfo_cnt[i] = '0;
      end
      fill_cnt  = 0;
      open_q    = 1'b0;
      hdr_type  = '0;
      hdr_track = '0;
      hdr_seq   = '0;
      hdr_bpos  = '0;
      str_pos   = '0;
      expected_packs.delete();
      pending_o <= 0;
    end else begin
      if (pack_i.valid && pack_i.ready) begin
        seen = {pack_i.out_type, pack_i.out_track, pack_i.out_sequence,
                pack_i.out_block_position, pack_i.payload_front, pack_i.payload_back,
                pack_i.pack_crc};
        if (expected_packs.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportLimit) begin
            $display("unexpected pack: type %h trk %h seq %h bpos %h front %h back %h crc %h",
                     seen.ptype, seen.track, seen.seq, seen.bpos, seen.front, seen.back,
                     seen.crc);
          end
        end else begin
          want = expected_packs.pop_front();
          if (seen !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= ReportLimit) begin
              $display("pack error exp: type %h trk %h seq %h bpos %h front %h back %h crc %h",
                       want.ptype, want.track, want.seq, want.bpos, want.front, want.back,
                       want.crc);
              $display("pack error act: type %h trk %h seq %h bpos %h front %h back %h crc %h",
                       seen.ptype, seen.track, seen.seq, seen.bpos, seen.front, seen.back,
                       seen.crc);
            end
          end
        end
      end
      if (txt_i.valid && txt_i.ready) begin
        frame_request(txt_i.opcode, txt_i.text_byte, txt_i.txt_type, txt_i.txt_track,
                      txt_i.txt_block, txt_i.string_start);
      end
      pending_o <= expected_packs.size();
    end
  end

  assign mismatches_o = mismatch_cnt;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: pack framer top-level test
// Drives directed and random text byte streams in bursts, stalls the pack
// channel on a shifting pattern and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import ctpf_pkg::*; import ctpf_tb_pkg::*; ();

  localparam int unsigned StringPhaseItems = 470;
  localparam int unsigned ChurnItems       = 300;
  localparam int unsigned DrainCycles      = 16;
  localparam int unsigned CycleLimit       = 200000;

  logic clk;
  logic rst_n;

  int          mismatches;
  int          pending;
  int unsigned sent       = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_mode = 0;
  logic [7:0]  stall_mask = 8'h00;

  ctpf_in_if  txt_if ();
  ctpf_out_if pack_if ();

  cd_text_pack_framer #(.BLOCK_COUNT(MaxBlocks)) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .txt_i  (txt_if),
    .pack_o (pack_if)
  );

  ctpf_scoreboard #(.BLOCK_COUNT(MaxBlocks)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .txt_i        (txt_if),
    .pack_i       (pack_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // pack channel backpressure: a new mode is drawn whenever the current one runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
      stall_mask = 8'($urandom);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: begin
        pack_if.ready <= 1'b1;
      end
      1: begin
        pack_if.ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        pack_if.ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        pack_if.ready <= stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[7:1]};
      end
    endcase
  end

  // one request, held until taken; valid stays up inside a burst
  task automatic send_req(input ctpf_op_e op, input logic [7:0] b, input logic [7:0] t,
                          input logic [6:0] trk, input logic [2:0] blk, input logic st);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        txt_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    txt_if.valid        <= 1'b1;
    txt_if.opcode       <= op;
    txt_if.text_byte    <= b;
    txt_if.txt_type     <= t;
    txt_if.txt_track    <= trk;
    txt_if.txt_block    <= blk;
    txt_if.string_start <= st;
    @(posedge clk);
    while (!txt_if.ready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // flush ignores every other field, so they carry junk
  task automatic send_flush();
    send_req(OP_FLUSH, 8'($urandom), 8'($urandom), 7'($urandom), 3'($urandom),
             1'($urandom));
  endtask

  // a well-formed string: start mark on the first byte, zero terminator last
  task automatic send_string(input logic [7:0] t, input logic [6:0] trk,
                             input logic [2:0] blk, input int unsigned len);
    logic [7:0] b;
    logic       st;
    for (int i = 0; i < len; i++) begin
      b  = (i == len - 1) ? 8'h00 : 8'($urandom_range(1, 255));
      st = (i == 0) || ($urandom_range(0, 40) == 0);
      send_req(OP_APPEND, b, t, trk, blk, st);
    end
  endtask

  initial begin
    logic [7:0]  str_type;
    logic [6:0]  str_track;
    logic [2:0]  str_block;
    int unsigned str_len;
    int unsigned pick;

    rst_n                <= 1'b0;
    txt_if.valid         <= 1'b0;
    txt_if.opcode        <= OP_APPEND;
    txt_if.text_byte     <= '0;
    txt_if.txt_type      <= '0;
    txt_if.txt_track     <= '0;
    txt_if.txt_block     <= '0;
    txt_if.string_start  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty flush, type and block changes, size-info packs,
    // one full pack, types outside the text range
    send_flush();
    send_req(OP_APPEND, 8'h00, FirstTextType, 7'd0, 3'd0, 1'b1);
    send_req(OP_APPEND, 8'hFF, FirstTextType, 7'd0, 3'd0, 1'b0);
    send_req(OP_APPEND, 8'h55, SizeinfoType, 7'd42, 3'd0, 1'b1);
    send_req(OP_APPEND, 8'hAA, SizeinfoType, 7'd1, 3'd7, 1'b0);
    send_req(OP_APPEND, 8'h01, SizeinfoType, 7'd1, 3'd7, 1'b0);
    send_flush();
    send_flush();
    for (int i = 0; i < PayloadBytes; i++) begin
      send_req(OP_APPEND, 8'(8'h30 + i), LastTextType, 7'd99, 3'd3, (i == 0));
    end
    send_req(OP_APPEND, 8'hA5, 8'h00, 7'd127, 3'd5, 1'b0);
    send_req(OP_APPEND, 8'h5A, 8'hFF, 7'd64, 3'd5, 1'b1);
    send_flush();

    // random strings with some flushes and noise requests mixed in
    str_block = 3'd0;
    while (sent < StringPhaseItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_flush();
      end else if (pick < 14) begin
        send_req(ctpf_op_e'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                 7'($urandom), 3'($urandom), 1'($urandom));
      end else begin
        str_type = ($urandom_range(0, 30) == 0) ? 8'($urandom)
                                                : 8'(FirstTextType + $urandom_range(0, 15));
        if ($urandom_range(0, 2) == 0) begin
          str_block = 3'($urandom_range(0, 7));
        end
        str_track = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
        str_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                : $urandom_range(1, 16);
        send_string(str_type, str_track, str_block, str_len);
      end
    end

    // one pack per request in block 0, enough to wrap its sequence number
    for (int i = 0; i < ChurnItems; i++) begin
      str_type = (i % 2 == 0) ? SizeinfoType : 8'(FirstTextType + $urandom_range(0, 14));
      send_req(OP_APPEND, 8'($urandom), str_type, 7'($urandom), 3'd0, 1'($urandom));
    end
    txt_if.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
